// ----- src/owbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int CFG_W              = 10;
    localparam int REG_COUNT          = 7;
    localparam int REG_IDX_W          = 3;
    localparam int TIMER_BITS_DEFAULT = 10;
    localparam int BYTE_W             = 8;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_SLOT_START    = 3'd3,
        REG_READ_WAIT     = 3'd4,
        REG_SLOT_HOLD     = 3'd5,
        REG_RECOVERY      = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_RD_LOW   = 4'd4,
        PH_RD_WAIT  = 4'd5,
        PH_RD_HOLD  = 4'd6,
        PH_WR_LOW   = 4'd7,
        PH_WR_HOLD  = 4'd8,
        PH_WR_REC   = 4'd9
    } phase_t;

    typedef logic [CFG_W-1:0] cfg_word_t;

    localparam cfg_word_t DEF_RESET_LOW     = 10'd490;
    localparam cfg_word_t DEF_PRESENCE_WAIT = 10'd68;
    localparam cfg_word_t DEF_RESET_TAIL    = 10'd422;
    localparam cfg_word_t DEF_SLOT_START    = 10'd2;
    localparam cfg_word_t DEF_READ_WAIT     = 10'd4;
    localparam cfg_word_t DEF_SLOT_HOLD     = 10'd62;
    localparam cfg_word_t DEF_RECOVERY      = 10'd2;

endpackage : owbm_pkg
`default_nettype wire

// ----- src/one_wire_bus_master.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Open-drain 1-Wire master sequencing reset, read-byte and write-byte
// operations from a stream of microsecond ticks.
// ----------------------------------------------------------------------------
// The result of a tick is registered and presented in the cycle after the tick is accepted.
// Throughput: one tick per cycle while the result side does not stall; the
// sequencer state updates in the same cycle the tick is taken, and the output register decouples the two sides.
// Reset: rst_n clears the sequencer to idle, the timing registers to their
// defaults, the presence result to "no device" and the read byte to zero.
module one_wire_bus_master #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [owbm_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [owbm_pkg::CFG_W-1:0]     cfg_data,
    // tick input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    action,
    input  wire logic [owbm_pkg::BYTE_W-1:0]    write_byte,
    input  wire logic                          line_level,
    // per-tick result
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               drive_low,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               device_missing,
    output logic [owbm_pkg::BYTE_W-1:0]         read_byte
);
    import owbm_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    typedef logic [TIMER_BITS-1:0] timer_t;

    // saturate to timer range, zero taken as one tick
    function automatic timer_t phase_len(input cfg_word_t v);
        logic [CMP_W-1:0] ext;
        timer_t           t;
        ext = CMP_W'(v);
        if (ext > TIMER_MAX)
            ext = TIMER_MAX;
        t = TIMER_BITS'(ext);
        if (t == '0)
            t = TIMER_ONE;
        return t;
    endfunction

    cfg_word_t              cfg_reg [REG_COUNT];
    phase_t                 phase_reg, phase_next;
    timer_t                 timer_reg, timer_next;
    logic [2:0]             bitcnt_reg, bitcnt_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic                   pres_reg, pres_next;
    logic                   drv_reg, drv_next;
    logic [BYTE_W-1:0]      last_read_reg, last_read_next;

    logic                   out_valid_reg;
    logic                   drive_now, busy_now, done_now;

    logic                   in_accept;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_RESET_LOW]     <= DEF_RESET_LOW;
            cfg_reg[REG_PRESENCE_WAIT] <= DEF_PRESENCE_WAIT;
            cfg_reg[REG_RESET_TAIL]    <= DEF_RESET_TAIL;
            cfg_reg[REG_SLOT_START]    <= DEF_SLOT_START;
            cfg_reg[REG_READ_WAIT]     <= DEF_READ_WAIT;
            cfg_reg[REG_SLOT_HOLD]     <= DEF_SLOT_HOLD;
            cfg_reg[REG_RECOVERY]      <= DEF_RECOVERY;
        end
        else if (cfg_we && (cfg_index < REG_IDX_W'(REG_COUNT)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // ------------------------------------------------------------- sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bitcnt_next    = bitcnt_reg;
        shift_next     = shift_reg;
        pres_next      = pres_reg;
        drv_next       = drv_reg;
        last_read_next = last_read_reg;
        busy_now       = 1'b0;
        done_now       = 1'b0;

        // start of an operation happens on the same tick
        if (phase_reg == PH_IDLE && action_t'(action) != ACT_TICK)
        begin
            bitcnt_next = '0;
            drv_next    = 1'b1;
            unique case (action_t'(action))
                ACT_RESET:
                begin
                    phase_next = PH_RST_LOW;
                    timer_next = phase_len(cfg_reg[REG_RESET_LOW]);
                end
                ACT_READ:
                begin
                    shift_next = '0;
                    phase_next = PH_RD_LOW;
                    timer_next = phase_len(cfg_reg[REG_SLOT_START]);
                end
                default:
                begin
                    shift_next = write_byte;
                    phase_next = PH_WR_LOW;
                    timer_next = phase_len(cfg_reg[REG_SLOT_START]);
                end
            endcase
        end

        drive_now = drv_next;

        if (phase_next != PH_IDLE)
        begin
            busy_now   = 1'b1;
            timer_next = timer_next - TIMER_ONE;
            if (timer_next == '0)
            begin
                unique case (phase_next)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                        timer_next = phase_len(cfg_reg[REG_PRESENCE_WAIT]);
                        drv_next   = 1'b0;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next  = line_level;
                        phase_next = PH_RST_TAIL;
                        timer_next = phase_len(cfg_reg[REG_RESET_TAIL]);
                        drv_next   = 1'b0;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_WAIT;
                        timer_next = phase_len(cfg_reg[REG_READ_WAIT]);
                        drv_next   = 1'b0;
                    end
                    PH_RD_WAIT:
                    begin
                        shift_next = {line_level, shift_next[BYTE_W-1:1]};
                        phase_next = PH_RD_HOLD;
                        timer_next = phase_len(cfg_reg[REG_SLOT_HOLD]);
                        drv_next   = 1'b0;
                    end
                    PH_RD_HOLD:
                    begin
                        bitcnt_next = bitcnt_next + 3'd1;
                        if (bitcnt_next == '0)
                        begin
                            last_read_next = shift_next;
                            phase_next     = PH_IDLE;
                            done_now       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RD_LOW;
                            timer_next = phase_len(cfg_reg[REG_SLOT_START]);
                            drv_next   = 1'b1;
                        end
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_HOLD;
                        timer_next = phase_len(cfg_reg[REG_SLOT_HOLD]);
                        drv_next   = ~shift_next[0];
                        shift_next = {1'b0, shift_next[BYTE_W-1:1]};
                    end
                    PH_WR_HOLD:
                    begin
                        phase_next = PH_WR_REC;
                        timer_next = phase_len(cfg_reg[REG_RECOVERY]);
                        drv_next   = 1'b0;
                    end
                    PH_WR_REC:
                    begin
                        bitcnt_next = bitcnt_next + 3'd1;
                        if (bitcnt_next == '0)
                        begin
                            phase_next = PH_IDLE;
                            done_now   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_WR_LOW;
                            timer_next = phase_len(cfg_reg[REG_SLOT_START]);
                            drv_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done_now   = 1'b1;
                    end
                endcase
                if (done_now)
                begin
                    timer_next = '0;
                    drv_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bitcnt_reg    <= '0;
            shift_reg     <= '0;
            pres_reg      <= 1'b1;
            drv_reg       <= 1'b0;
            last_read_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bitcnt_reg    <= bitcnt_next;
            shift_reg     <= shift_next;
            pres_reg      <= pres_next;
            drv_reg       <= drv_next;
            last_read_reg <= last_read_next;
        end
    end

    // -------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            drive_low      <= drive_now;
            busy_res       <= busy_now;
            done_res       <= done_now;
            device_missing <= pres_next;
            read_byte      <= last_read_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------ assertions
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (timer_reg == '0))
        else $error("timer not cleared while idle");

    a_busy_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (timer_reg != '0))
        else $error("timer expired inside a phase");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && done_now) |=> (phase_reg == PH_IDLE && !drv_reg))
        else $error("finished operation left sequencer active");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

endmodule : one_wire_bus_master
`default_nettype wire

// ----- bench/tb_one_wire_bus_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the 1-Wire bus master. A queue of ticks feeds a
// clocked driver; a clocked monitor compares every per-tick result against
// a local model of the bus sequencer. Timing registers are reprogrammed
// between runs of traffic (defaults, all ones, all zeros, small random
// values, maximum reset pulse), both handshakes idle at random, and the
// result side holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

    import owbm_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int IDLE_PCT      = 21;
    localparam int CALM_FROM     = 1200;
    localparam int CALM_TO       = 1600;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 90;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [REG_IDX_W-1:0] NO_SUCH_REG = 3'd7;
    localparam cfg_word_t            CFG_MAX     = 10'd1023;

    typedef struct packed {
        action_t             act;
        logic [BYTE_W-1:0]   wbyte;
        logic                line;
    } tick_item_t;

    typedef struct packed {
        logic                drive_low;
        logic                busy;
        logic                done;
        logic                device_missing;
        logic [BYTE_W-1:0]   read_byte;
    } tick_result_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index  = '0;
    cfg_word_t             cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [1:0]            action     = ACT_TICK;
    logic [BYTE_W-1:0]     write_byte = '0;
    logic                  line_level = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic                  device_missing;
    logic [BYTE_W-1:0]     read_byte;

    one_wire_bus_master u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .write_byte     (write_byte),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .device_missing (device_missing),
        .read_byte      (read_byte)
    );

    // ticks waiting to be offered, and per-tick results still owed by the block
    tick_item_t    ticks_pending [$];
    tick_result_t  results_due   [$];
    int            ticks_queued  = 0;
    int            ticks_checked = 0;
    int            errors        = 0;
    int            cycle_count   = 0;
    int            hold_left     = 0;
    bit            held_off      = 1'b0;
    bit            calm;

    // local copy of the sequencer
    cfg_word_t           timing_reg [REG_COUNT];
    phase_t              seq_phase;
    logic [CFG_W-1:0]    seq_timer;
    logic [2:0]          seq_bit;
    logic [BYTE_W-1:0]   seq_shift;
    logic                seq_missing;
    logic                seq_drive;
    logic [BYTE_W-1:0]   seq_last_read;

    assign calm = (ticks_checked >= CALM_FROM) && (ticks_checked < CALM_TO);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void load_phase(input phase_t p, input reg_idx_t r, input logic drv);
        seq_phase = p;
        seq_timer = (timing_reg[r] == '0) ? 10'd1 : timing_reg[r];
        seq_drive = drv;
    endfunction

    function automatic tick_result_t sequence_tick(input tick_item_t it);
        tick_result_t res;
        logic         op_done;
        logic         drv_now;
        res     = '0;
        op_done = 1'b0;
        if (seq_phase == PH_IDLE && it.act != ACT_TICK)
        begin
            seq_bit = 3'd0;
            case (it.act)
                ACT_RESET: load_phase(PH_RST_LOW, REG_RESET_LOW, 1'b1);
                ACT_READ:
                begin
                    seq_shift = '0;
                    load_phase(PH_RD_LOW, REG_SLOT_START, 1'b1);
                end
                default:
                begin
                    seq_shift = it.wbyte;
                    load_phase(PH_WR_LOW, REG_SLOT_START, 1'b1);
                end
            endcase
        end
        drv_now = seq_drive;
        if (seq_phase != PH_IDLE)
        begin
            res.busy  = 1'b1;
            seq_timer = seq_timer - 10'd1;
            if (seq_timer == '0)
            begin
                case (seq_phase)
                    PH_RST_LOW: load_phase(PH_RST_WAIT, REG_PRESENCE_WAIT, 1'b0);
                    PH_RST_WAIT:
                    begin
                        seq_missing = it.line;
                        load_phase(PH_RST_TAIL, REG_RESET_TAIL, 1'b0);
                    end
                    PH_RD_LOW: load_phase(PH_RD_WAIT, REG_READ_WAIT, 1'b0);
                    PH_RD_WAIT:
                    begin
                        seq_shift = {it.line, seq_shift[BYTE_W-1:1]};
                        load_phase(PH_RD_HOLD, REG_SLOT_HOLD, 1'b0);
                    end
                    PH_RD_HOLD:
                    begin
                        seq_bit = seq_bit + 3'd1;
                        if (seq_bit == 3'd0)
                        begin
                            seq_last_read = seq_shift;
                            op_done       = 1'b1;
                        end
                        else
                            load_phase(PH_RD_LOW, REG_SLOT_START, 1'b1);
                    end
                    PH_WR_LOW:
                    begin
                        // a 0 bit keeps the line low through the hold
                        load_phase(PH_WR_HOLD, REG_SLOT_HOLD, ~seq_shift[0]);
                        seq_shift = seq_shift >> 1;
                    end
                    PH_WR_HOLD: load_phase(PH_WR_REC, REG_RECOVERY, 1'b0);
                    PH_WR_REC:
                    begin
                        seq_bit = seq_bit + 3'd1;
                        if (seq_bit == 3'd0)
                            op_done = 1'b1;
                        else
                            load_phase(PH_WR_LOW, REG_SLOT_START, 1'b1);
                    end
                    default: op_done = 1'b1;
                endcase
                if (op_done)
                begin
                    seq_phase = PH_IDLE;
                    seq_timer = '0;
                    seq_drive = 1'b0;
                end
            end
        end
        res.drive_low      = drv_now;
        res.done           = op_done;
        res.device_missing = seq_missing;
        res.read_byte      = seq_last_read;
        return res;
    endfunction

    // driver: offers queued ticks, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= ACT_TICK;
            write_byte <= '0;
            line_level <= 1'b0;
        end
        else
        begin
            tick_item_t cur;
            tick_item_t nxt;
            if (in_valid && !in_stall)
            begin
                cur = '{act: action_t'(action), wbyte: write_byte, line: line_level};
                results_due.push_back(sequence_tick(cur));
            end
            if (!in_valid || !in_stall)
            begin
                if (ticks_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt        = ticks_pending.pop_front();
                    in_valid   <= 1'b1;
                    action     <= nxt.act;
                    write_byte <= nxt.wbyte;
                    line_level <= nxt.line;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction, drives out_stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            tick_result_t got;
            tick_result_t want;
            if (out_valid && !out_stall)
            begin
                got = '{drive_low: drive_low, busy: busy_res, done: done_res,
                        device_missing: device_missing, read_byte: read_byte};
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result transaction: %p", got);
                end
                else
                begin
                    want = results_due.pop_front();
                    ticks_checked++;
                    if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
                        got.done !== want.done ||
                        got.device_missing !== want.device_missing ||
                        got.read_byte !== want.read_byte)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("tick %0d mismatch: expected %p, got %p",
                                     ticks_checked, want, got);
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!held_off && ticks_checked >= HOLD_AT)
            begin
                // long hold-off so the block backs up into its input
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_tick(input action_t act, input logic [BYTE_W-1:0] wb, input logic line);
        ticks_pending.push_back('{act: act, wbyte: wb, line: line});
        ticks_queued++;
    endtask

    task automatic queue_random(input int n, input int cmd_pct);
        action_t act;
        for (int i = 0; i < n; i++)
        begin
            act = ($urandom_range(99) < cmd_pct) ? action_t'($urandom_range(3, 1)) : ACT_TICK;
            push_tick(act, BYTE_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        wait (ticks_checked == ticks_queued);
        @(posedge clk);
    endtask

    // run plain ticks until the sequencer is back at idle
    task automatic settle_sequencer();
        wait_drained();
        while (seq_phase != PH_IDLE)
        begin
            push_tick(ACT_TICK, BYTE_W'($urandom), 1'($urandom));
            wait_drained();
        end
    endtask

    // called at a clock edge; leaves cfg_we high for the caller to drop
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input cfg_word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < REG_COUNT)
            timing_reg[idx] = val;
    endtask

    task automatic set_all(input cfg_word_t val);
        for (int i = 0; i < REG_COUNT; i++)
            set_reg(REG_IDX_W'(i), val);
    endtask

    initial
    begin
        timing_reg[REG_RESET_LOW]     = DEF_RESET_LOW;
        timing_reg[REG_PRESENCE_WAIT] = DEF_PRESENCE_WAIT;
        timing_reg[REG_RESET_TAIL]    = DEF_RESET_TAIL;
        timing_reg[REG_SLOT_START]    = DEF_SLOT_START;
        timing_reg[REG_READ_WAIT]     = DEF_READ_WAIT;
        timing_reg[REG_SLOT_HOLD]     = DEF_SLOT_HOLD;
        timing_reg[REG_RECOVERY]      = DEF_RECOVERY;
        seq_phase     = PH_IDLE;
        seq_timer     = '0;
        seq_bit       = '0;
        seq_shift     = '0;
        seq_missing   = 1'b1;
        seq_drive     = 1'b0;
        seq_last_read = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // default timings: a write starts, commands while busy are dropped
        push_tick(ACT_TICK, 8'h00, 1'b0);
        push_tick(ACT_TICK, 8'hFF, 1'b1);
        push_tick(ACT_WRITE, 8'hFF, 1'b0);
        push_tick(ACT_READ, 8'h00, 1'b1);
        push_tick(ACT_RESET, 8'h5A, 1'b1);
        push_tick(ACT_WRITE, 8'h00, 1'b0);
        queue_random(100, 15);

        // retime while the write is still in flight
        wait_drained();
        set_all(10'd1);
        cfg_we <= 1'b0;
        settle_sequencer();

        // one-tick phases: a read of 24 ticks, a command on its last tick
        // is dropped, then a reset that sees a presence pulse
        push_tick(ACT_READ, 8'h00, 1'b1);
        for (int k = 1; k < 23; k++)
            push_tick(ACT_TICK, 8'h00, k[0]);
        push_tick(ACT_WRITE, 8'h00, 1'b1);
        push_tick(ACT_RESET, 8'h00, 1'b1);
        push_tick(ACT_TICK, 8'h00, 1'b0);
        push_tick(ACT_TICK, 8'h00, 1'b1);
        push_tick(ACT_WRITE, 8'h00, 1'b1);
        queue_random(80, 20);

        // zero lengths act as one tick; an unknown index is ignored
        wait_drained();
        set_all(10'd0);
        set_reg(NO_SUCH_REG, 10'd5);
        cfg_we <= 1'b0;
        queue_random(80, 20);

        for (int round = 0; round < 2; round++)
        begin
            wait_drained();
            for (int i = 0; i < REG_COUNT; i++)
                set_reg(REG_IDX_W'(i), cfg_word_t'($urandom_range(6, 1)));
            cfg_we <= 1'b0;
            queue_random(130, 15);
        end

        // longest reset pulse the register allows
        settle_sequencer();
        set_all(10'd1);
        set_reg(REG_RESET_LOW, CFG_MAX);
        cfg_we <= 1'b0;
        push_tick(ACT_RESET, 8'h00, 1'b1);
        queue_random(1040, 10);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        errors += results_due.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
